// ===== sv/xtea_pkg.sv =====
package xtea_pkg;

  localparam int ROUNDS = 32;
  // two half-round cells per feistel cycle
  localparam int NCELLS = 2 * ROUNDS;

  localparam logic [31:0] DELTA = 32'h9E3779B9;
  localparam logic [63:0] DEC_SUM_WIDE = 64'(DELTA) * 64'(ROUNDS);
  localparam logic [31:0] DEC_SUM = DEC_SUM_WIDE[31:0];

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  localparam logic [31:0] KEY0_RST = 32'h00112233;
  localparam logic [31:0] KEY1_RST = 32'h44556677;
  localparam logic [31:0] KEY2_RST = 32'h8899AABB;
  localparam logic [31:0] KEY3_RST = 32'hCCDDEEFF;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic        valid;
    logic        op;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } stage_t;

  function automatic logic [31:0] mix(input logic [31:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== sv/xtea_if.sv =====
interface xtea_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] block_lo;
  logic [31:0] block_hi;

  modport source (output valid, output req_type, output block_lo, output block_hi,
                  input ready);
  modport sink (input valid, input req_type, input block_lo, input block_hi,
                output ready);
endinterface

interface xtea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_lo;
  logic [31:0] result_hi;

  modport source (output valid, output result_lo, output result_hi, input ready);
  modport sink (input valid, input result_lo, input result_hi, output ready);
endinterface

// ===== sv/xtea_cell.sv =====
module xtea_cell
  import xtea_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   second,
  input  key_t   key,
  input  stage_t din,
  output stage_t dout
);

  logic        upd_lo;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [1:0]  key_idx;
  logic [31:0] f;
  logic [31:0] res;
  stage_t      dout_next;

  // v0 is the half updated by the first half-round of encrypt and the second of decrypt
  assign upd_lo  = (din.op == second);
  assign src     = upd_lo ? din.v1 : din.v0;
  assign tgt     = upd_lo ? din.v0 : din.v1;
  assign key_idx = upd_lo ? din.sum[1:0] : din.sum[12:11];
  assign f       = mix(src) ^ (din.sum + key[key_idx]);
  assign res     = (din.op == OP_DECRYPT) ? (tgt - f) : (tgt + f);

  always_comb begin
    dout_next       = din;
    dout_next.valid = din.valid;
    if (upd_lo) begin
      dout_next.v0 = res;
    end else begin
      dout_next.v1 = res;
    end
    if (!second) begin
      dout_next.sum = (din.op == OP_DECRYPT) ? (din.sum - DELTA) : (din.sum + DELTA);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= dout_next.valid;
    end
    if (en) begin
      dout.op  <= dout_next.op;
      dout.v0  <= dout_next.v0;
      dout.v1  <= dout_next.v1;
      dout.sum <= dout_next.sum;
    end
  end

endmodule

// ===== sv/xtea_obuf.sv =====
module xtea_obuf
  import xtea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] push_lo,
  input  logic [31:0] push_hi,
  output logic        space,
  xtea_rsp_if.source  rsp
);

  logic [31:0] lo [2];
  logic [31:0] hi [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        pop;

  assign pop   = rsp.valid && rsp.ready;
  assign space = (count != 2'd2);

  assign rsp.valid     = (count != 2'd0);
  assign rsp.result_lo = lo[rd_ptr];
  assign rsp.result_hi = hi[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      lo[wr_ptr] <= push_lo;
      hi[wr_ptr] <= push_hi;
    end
  end

endmodule

// ===== sv/xtea_block_cipher.sv =====
// XTEA cipher, 64-bit block, 128-bit key in four words (key_word0..3 at
// cfg_index 0..3). req_type 0 encrypts, 1 decrypts; each request transaction
// gives one response transaction. The 32 feistel cycles run through a chain of
// 64 half-round cells, one register each, ahead of the 2-entry output buffer.
// A block enters every cycle, for a sustained rate of one block per clock,
// unless the request side stalls, which it does only when the output buffer
// is full. Write keys only while no block is in flight.
module xtea_block_cipher
  import xtea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  xtea_req_if.sink    req,
  xtea_rsp_if.source  rsp
);

  key_t   key;
  stage_t pipe [NCELLS+1];
  logic   en;
  logic   push;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= KEY0_RST;
      key[1] <= KEY1_RST;
      key[2] <= KEY2_RST;
      key[3] <= KEY3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.ready = en;

  // valid, op, v0, v1, sum
  assign pipe[0] = {req.valid, req.req_type, req.block_lo, req.block_hi,
                    ((req.req_type == OP_DECRYPT) ? DEC_SUM : 32'd0)};

  for (genvar i = 0; i < NCELLS; i++) begin : g_chain
    xtea_cell u_round (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .second (1'(i % 2)),
      .key    (key),
      .din    (pipe[i]),
      .dout   (pipe[i+1])
    );
  end

  assign push = en && pipe[NCELLS].valid;

  xtea_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_lo (pipe[NCELLS].v0),
    .push_hi (pipe[NCELLS].v1),
    .space   (en),
    .rsp     (rsp)
  );

  a_enter: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> pipe[1].valid)
    else $error("accepted request did not enter the first cell");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe[NCELLS].valid) && $stable(pipe[NCELLS].v0))
    else $error("cell chain moved while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp.valid && !pipe[NCELLS].valid)
    else $error("result visible right after reset");

  a_push_out: assert property (@(posedge clk) disable iff (rst)
    push |=> rsp.valid)
    else $error("pushed result not offered");

endmodule
